// ----- sv/page_frame_replacement_top_assert.svh -----
// Assertion macros for the page frame replacement block
`ifndef PAGE_FRAME_REPLACEMENT_TOP_ASSERT_SVH
`define PAGE_FRAME_REPLACEMENT_TOP_ASSERT_SVH

// condition must hold at every edge outside reset
`define PFR_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("page frame replacement: invariant violated");

// trigger in one cycle implies the consequence in the next
`define PFR_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("page frame replacement: sequence violated");

`endif

// ----- sv/pfr_pkg.sv -----
package pfr_pkg;

  // configuration register indexes and port widths
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 7;
  localparam logic [CFG_AW-1:0] CFG_POLICY_MODE   = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_FRAMES_IN_USE = 1'd1;

  // fixed field widths
  localparam int ADDR_W     = 32;
  localparam int EV_PAGE_W  = 20;
  localparam int COUNT_W    = 32;
  localparam logic [CFG_DW-1:0] FRAMES_RESET = 7'd64;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } pfr_state_t;

  // command broadcast to every frame cell
  typedef struct packed {
    logic shift;  // take neighbour contents over the window [from, last)
    logic load;   // write new page and dirty bit at the target cell
    logic mark;   // set the dirty bit at the target cell
  } pfr_cmd_t;

endpackage

// ----- sv/pfr_cell.sv -----
module pfr_cell import pfr_pkg::*; #(
  parameter int IDX = 0,
  parameter int PW  = 20,
  parameter int IW  = 6,
  parameter int OW  = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmp_en,
  input  logic [OW-1:0] occ,
  input  logic [PW-1:0] probe_page,
  input  pfr_cmd_t      cmd,
  input  logic [IW-1:0] from_idx,
  input  logic [IW-1:0] last_idx,
  input  logic [IW-1:0] tgt_idx,
  input  logic [PW-1:0] load_page,
  input  logic          load_dirty,
  input  logic [PW-1:0] nb_page,
  input  logic          nb_dirty,
  output logic [PW-1:0] page,
  output logic          dirty,
  output logic          match
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [OW-1:0] MY_POS = OW'(IDX);

  logic [PW-1:0] page_r, page_nxt;
  logic          dirty_r, dirty_nxt;
  logic          match_r, match_nxt;
  logic          resident;
  logic          at_tgt;
  logic          in_window;

  assign resident  = MY_POS < occ;
  assign at_tgt    = (MY_IDX == tgt_idx);
  assign in_window = (MY_IDX >= from_idx) && (MY_IDX < last_idx);

  // compare against the probe when a beat is taken, hold otherwise
  assign match_nxt = cmp_en ? (resident && (page_r == probe_page)) : match_r;

  // load beats mark, mark beats shift; load and shift never hit the same cell
  always_comb begin
    page_nxt  = page_r;
    dirty_nxt = dirty_r;
    if (cmd.load && at_tgt) begin
      page_nxt  = load_page;
      dirty_nxt = load_dirty;
    end else if (cmd.mark && at_tgt) begin
      dirty_nxt = 1'b1;
    end else if (cmd.shift && in_window) begin
      page_nxt  = nb_page;
      dirty_nxt = nb_dirty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      dirty_r <= dirty_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

  assign page  = page_r;
  assign dirty = dirty_r;
  assign match = match_r;

endmodule

// ----- sv/page_frame_replacement_top.sv -----
// Page frame replacement engine, FIFO or LRU order with dirty tracking.
// Input channel (in_*): one beat per memory access, a byte address and a
// write flag. Output channel (out_*): one beat per access with hit and
// eviction flags, the evicted page and the running fill and write-back
// counts. Both channels use valid/stall; a beat moves when valid is high
// and stall is low.
// Frames sit in a row of cells, oldest first. At the accepting edge every
// cell compares the incoming page; when the access commits the row shifts one
// place where an entry leaves and the new or reordered page is loaded at
// the newest end, and the result enters the output register.
// Output valid rises at the edge where the access commits from the exec
// state; no new access is taken until the compare-then-shift pass commits.
// If the receiver stalls, the finished result waits in the output
// register and the next access is still compared, then holds until the
// register frees.
// Configuration (cfg_*) is for the user to write only while idle; the block
// does not enforce it. Index 0 selects LRU, index 1 sets the frames in use.
// Reset empties all frames, clears both counters and sets FIFO order with
// 64 frames in use; no clearing pass is needed.
module page_frame_replacement_top import pfr_pkg::*; #(
  parameter int MAX_FRAMES = 64,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_index,
  input  logic [CFG_DW-1:0]     cfg_data,
  // access channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_W-1:0]     in_access_address,
  input  logic                  in_is_write,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic                  out_evicted,
  output logic                  out_evicted_dirty,
  output logic [EV_PAGE_W-1:0]  out_evicted_page,
  output logic [COUNT_W-1:0]    out_disk_reads,
  output logic [COUNT_W-1:0]    out_disk_writes
);

  `include "page_frame_replacement_top_assert.svh"

  localparam int PW = ADDR_W - PAGE_SHIFT;
  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int OW = $clog2(MAX_FRAMES + 1);
  localparam logic [OW-1:0] OCC_MAX = OW'(MAX_FRAMES);

  // configuration registers
  logic              policy_r;
  logic [CFG_DW-1:0] frames_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
      frames_r <= FRAMES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY_MODE:   policy_r <= cfg_data[0];
        CFG_FRAMES_IN_USE: frames_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // effective frame limit, clamped to 1..MAX_FRAMES
  logic [OW-1:0] lim;
  always_comb begin
    if (frames_r == '0) begin
      lim = OW'(1);
    end else if (32'(frames_r) > MAX_FRAMES) begin
      lim = OCC_MAX;
    end else begin
      lim = OW'(frames_r);
    end
  end

  // sequencer and request registers
  pfr_state_t      state_r, state_nxt;
  logic [PW-1:0]   req_page_r;
  logic            req_wr_r;
  logic [OW-1:0]   occ_r, occ_nxt;
  logic [COUNT_W-1:0] reads_r, reads_nxt;
  logic [COUNT_W-1:0] writes_r, writes_nxt;
  logic            out_valid_r;
  logic            in_accept;
  logic            commit;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign commit    = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_accept) state_nxt = ST_EXEC;
      ST_EXEC: if (commit)    state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_page_r <= in_access_address[ADDR_W-1:PAGE_SHIFT];
      req_wr_r   <= in_is_write;
    end
  end

  // cell row
  logic [PW-1:0]         cell_page  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] cell_dirty;
  logic [MAX_FRAMES-1:0] cell_match;
  pfr_cmd_t              cmd;
  logic [IW-1:0]         from_idx, last_idx, tgt_idx;
  logic                  load_dirty;

  for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
    logic [PW-1:0] nb_page;
    logic          nb_dirty;
    if (k == MAX_FRAMES - 1) begin : g_end
      assign nb_page  = '0;
      assign nb_dirty = 1'b0;
    end else begin : g_mid
      assign nb_page  = cell_page[k+1];
      assign nb_dirty = cell_dirty[k+1];
    end
    pfr_cell #(.IDX(k), .PW(PW), .IW(IW), .OW(OW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmp_en     (in_accept),
      .occ        (occ_r),
      .probe_page (in_access_address[ADDR_W-1:PAGE_SHIFT]),
      .cmd        (cmd),
      .from_idx   (from_idx),
      .last_idx   (last_idx),
      .tgt_idx    (tgt_idx),
      .load_page  (req_page_r),
      .load_dirty (load_dirty),
      .nb_page    (nb_page),
      .nb_dirty   (nb_dirty),
      .page       (cell_page[k]),
      .dirty      (cell_dirty[k]),
      .match      (cell_match[k])
    );
  end

  // hit slot and its dirty bit: at most one cell matches
  logic          hit;
  logic [IW-1:0] slot;
  logic          slot_dirty;
  always_comb begin
    slot       = '0;
    slot_dirty = 1'b0;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      slot       = slot | (cell_match[k] ? IW'(k) : '0);
      slot_dirty = slot_dirty | (cell_match[k] & cell_dirty[k]);
    end
  end
  assign hit = |cell_match;

  logic evict;
  logic [OW-1:0] occ_m1;
  logic [PW+EV_PAGE_W-1:0] head_page_ext;

  assign evict         = !hit && (occ_r >= lim);
  assign occ_m1        = occ_r - 1'b1;
  assign head_page_ext = {{EV_PAGE_W{1'b0}}, cell_page[0]};

  // command decode for the committing beat
  always_comb begin
    cmd        = '0;
    from_idx   = '0;
    last_idx   = occ_m1[IW-1:0];
    tgt_idx    = occ_m1[IW-1:0];
    load_dirty = req_wr_r;
    occ_nxt    = occ_r;
    reads_nxt  = reads_r;
    writes_nxt = writes_r;
    if (commit) begin
      if (hit) begin
        if (policy_r) begin
          cmd.shift  = 1'b1;
          cmd.load   = 1'b1;
          from_idx   = slot;
          load_dirty = slot_dirty | req_wr_r;
        end else begin
          cmd.mark = req_wr_r;
          tgt_idx  = slot;
        end
      end else if (evict) begin
        cmd.shift  = 1'b1;
        cmd.load   = 1'b1;
        reads_nxt  = reads_r + 1'b1;
        writes_nxt = writes_r + COUNT_W'(cell_dirty[0]);
      end else begin
        cmd.load  = 1'b1;
        tgt_idx   = occ_r[IW-1:0];
        occ_nxt   = occ_r + 1'b1;
        reads_nxt = reads_r + 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      reads_r     <= '0;
      writes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      reads_r  <= reads_nxt;
      writes_r <= writes_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  logic                 out_hit_r, out_ev_r, out_ev_dirty_r;
  logic [EV_PAGE_W-1:0] out_ev_page_r;
  logic [COUNT_W-1:0]   out_reads_r, out_writes_r;

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r      <= hit;
      out_ev_r       <= evict;
      out_ev_dirty_r <= evict & cell_dirty[0];
      out_ev_page_r  <= evict ? head_page_ext[EV_PAGE_W-1:0] : '0;
      out_reads_r    <= reads_nxt;
      out_writes_r   <= writes_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evicted       = out_ev_r;
  assign out_evicted_dirty = out_ev_dirty_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_disk_reads    = out_reads_r;
  assign out_disk_writes   = out_writes_r;

  // checks
  `PFR_ASSERT_ALWAYS(a_occ_bound, occ_r <= OCC_MAX)
  `PFR_ASSERT_ALWAYS(a_single_match, $onehot0(cell_match))
  `PFR_ASSERT_NEXT(a_append_grows, commit && !hit && !evict, occ_r == $past(occ_r) + 1'b1)
  `PFR_ASSERT_NEXT(a_commit_shows, commit, out_valid && (out_hit != 1'b1 || !out_evicted))

endmodule
